// ----- hw/rtl/ntc_temperature_and_level_check_core_assert.svh -----
`ifndef NTC_TEMPERATURE_AND_LEVEL_CHECK_CORE_ASSERT_SVH
`define NTC_TEMPERATURE_AND_LEVEL_CHECK_CORE_ASSERT_SVH

// same-cycle implication
`define NTC_TLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ntc_tlc same-cycle check failed");

// next-cycle implication
`define NTC_TLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ntc_tlc next-cycle check failed");

`endif

// ----- hw/rtl/ntc_tlc_pkg.sv -----
package ntc_tlc_pkg;

	localparam int SampleW    = 12;
	localparam int TempW      = 7;
	localparam int CountW     = 8;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 12;
	localparam int RomAddrW   = 8;
	localparam int RomEntries = 100;
	localparam int TableSize  = 100;

	localparam logic [SampleW-1:0] FilterReset = 12'd2200;
	localparam logic [TempW-1:0]   OpenTemp    = 7'd56;
	localparam logic [TempW-1:0]   MaxTemp     = 7'd99;

	localparam logic [SampleW-1:0] ShortThrReset = 12'd100;
	localparam logic [SampleW-1:0] OpenThrReset  = 12'd4000;
	localparam logic [SampleW-1:0] WaterThrReset = 12'd2048;
	localparam logic [CountW-1:0]  WaterCntReset = 8'd16;
	localparam logic [CountW-1:0]  WaterMinReset = 8'd8;

	localparam logic [CfgIdxW-1:0] RegShortThr = 3'd0;
	localparam logic [CfgIdxW-1:0] RegOpenThr  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegWaterThr = 3'd2;
	localparam logic [CfgIdxW-1:0] RegWaterCnt = 3'd3;
	localparam logic [CfgIdxW-1:0] RegWaterMin = 3'd4;

	localparam logic ReqTemp  = 1'b0;
	localparam logic ReqLevel = 1'b1;

	localparam logic [SampleW-1:0] NtcRom [RomEntries] = '{
		12'd3974, 12'd3968, 12'd3962, 12'd3955, 12'd3949, 12'd3942, 12'd3935, 12'd3927,
		12'd3919, 12'd3911, 12'd3901, 12'd3892, 12'd3882, 12'd3873, 12'd3863, 12'd3853,
		12'd3842, 12'd3831, 12'd3820, 12'd3808, 12'd3795, 12'd3782, 12'd3768, 12'd3753,
		12'd3738, 12'd3723, 12'd3707, 12'd3692, 12'd3677, 12'd3663, 12'd3650, 12'd3633,
		12'd3616, 12'd3599, 12'd3580, 12'd3560, 12'd3539, 12'd3517, 12'd3495, 12'd3471,
		12'd3448, 12'd3424, 12'd3400, 12'd3376, 12'd3353, 12'd3332, 12'd3306, 12'd3281,
		12'd3255, 12'd3229, 12'd3202, 12'd3176, 12'd3149, 12'd3122, 12'd3094, 12'd3066,
		12'd3037, 12'd3007, 12'd2977, 12'd2945, 12'd2912, 12'd2881, 12'd2849, 12'd2817,
		12'd2784, 12'd2751, 12'd2718, 12'd2684, 12'd2650, 12'd2616, 12'd2582, 12'd2548,
		12'd2514, 12'd2480, 12'd2447, 12'd2413, 12'd2381, 12'd2349, 12'd2317, 12'd2285,
		12'd2253, 12'd2221, 12'd2189, 12'd2157, 12'd2124, 12'd2091, 12'd2058, 12'd2024,
		12'd1990, 12'd1955, 12'd1919, 12'd1885, 12'd1853, 12'd1821, 12'd1790, 12'd1759,
		12'd1728, 12'd1698, 12'd1668, 12'd1638
	};

	typedef struct packed {
		logic               req_type;
		logic [SampleW-1:0] sample;
	} req_t;

	typedef struct packed {
		logic [TempW-1:0] temperature;
		logic             short_fault;
		logic             open_fault;
		logic             kettle_present;
		logic             level_test_active;
		logic             water_low;
		logic             pad_timer_reload;
	} rsp_t;

	typedef enum logic [1:0] {
		StIdle,
		StEval,
		StSearch,
		StDone
	} state_t;

	// entries past the stored table read as zero
	function automatic logic [SampleW-1:0] rom_read(input logic [RomAddrW-1:0] addr);
		logic [SampleW-1:0] data;
		data = '0;
		if (addr < RomAddrW'(RomEntries)) begin
			data = NtcRom[addr[6:0]];
		end
		return data;
	endfunction

endpackage

// ----- hw/rtl/ntc_tlc_search.sv -----
module ntc_tlc_search
	import ntc_tlc_pkg::*;
#(
	parameter int TABLE_SIZE = TableSize,
	localparam int IdxW = $clog2(TABLE_SIZE)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SampleW-1:0] value,
	output logic               done,
	output logic [IdxW-1:0]    index
);

	localparam logic [IdxW-1:0] HiInit  = IdxW'(TABLE_SIZE - 1);
	localparam logic [IdxW-1:0] MidInit = IdxW'((TABLE_SIZE - 1) / 2);

	logic               busy_q;
	logic [SampleW-1:0] value_q;
	logic [IdxW-1:0]    lo_q, hi_q, mid_q;
	logic [IdxW-1:0]    lo_d, hi_d;
	logic [IdxW:0]      sum_d;
	logic [SampleW-1:0] entry;
	logic               lt, gt;

	assign entry = rom_read(RomAddrW'(mid_q));
	assign lt    = value_q < entry;
	assign gt    = value_q > entry;
	assign done  = busy_q && ((lo_q == hi_q) || (!lt && !gt));
	assign index = mid_q;

	always_comb begin
		lo_d = lo_q;
		hi_d = hi_q;
		if (lt) begin
			lo_d = mid_q + IdxW'(1);
		end else if (gt) begin
			hi_d = mid_q;
		end
		sum_d = {1'b0, lo_d} + {1'b0, hi_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			value_q <= value;
			lo_q    <= '0;
			hi_q    <= HiInit;
			mid_q   <= MidInit;
		end else if (busy_q && !done) begin
			lo_q  <= lo_d;
			hi_q  <= hi_d;
			mid_q <= sum_d[IdxW:1];
		end
	end

endmodule

// ----- hw/rtl/ntc_temperature_and_level_check_core.sv -----
// NTC temperature and water-level check. Each transaction on req carries one
// 12-bit ADC sample tagged as temperature or water level and produces exactly
// one transaction on rsp with the updated status. Level samples and faulted
// temperature samples pass through StEval and StDone before rsp_valid
// rises. A valid temperature sample also passes through StSearch between
// them, a binary search over the NTC table with one table compare per cycle
// in the search unit. req_stall stays high from acceptance until the result
// is loaded into the rsp register, so the next request is accepted in the
// cycle after that load at the earliest. A waiting result does not block the
// next request. Registers are written on cfg only while the block is idle;
// cfg_ready is high in that state. Unknown register indexes are ignored.
module ntc_temperature_and_level_check_core
	import ntc_tlc_pkg::*;
#(
	parameter int TABLE_SIZE = TableSize
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  req_t                req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rsp_t                rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int IdxW = $clog2(TABLE_SIZE);
	localparam int ExtW = IdxW + TempW;

	state_t state_q, state_d;

	logic [SampleW-1:0] short_thr_q, open_thr_q, water_thr_q;
	logic [CountW-1:0]  water_cnt_q, water_min_q;

	logic               kind_q;
	logic [SampleW-1:0] x_q;
	logic [SampleW-1:0] filt_q;
	logic [TempW-1:0]   temp_q;
	logic               present_q, short_q, open_q, active_q, low_q, reload_q;
	logic [CountW-1:0]  lvl_cnt_q, low_cnt_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               req_acc, out_free, search_start, search_done;
	logic [IdxW-1:0]    search_idx;
	logic [ExtW-1:0]    idx_ext;
	logic [TempW-1:0]   temp_found;
	logic [SampleW+2:0] filt_sum;
	logic [SampleW-1:0] filt_new;
	logic [CountW-1:0]  lvl_cnt_inc, low_cnt_inc;
	logic               is_short, is_open;

	assign req_stall = (state_q != StIdle);
	assign req_acc   = req_valid && !req_stall;
	assign cfg_ready = (state_q == StIdle);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_short = (x_q <= short_thr_q);
	assign is_open  = (x_q >= open_thr_q);

	// f = (7f + x) / 8
	assign filt_sum = {filt_q, 3'b000} - {3'b000, filt_q} + {3'b000, x_q};
	assign filt_new = filt_sum[SampleW+2:3];

	assign lvl_cnt_inc = lvl_cnt_q + CountW'(1);
	assign low_cnt_inc = (x_q >= water_thr_q) ? low_cnt_q + CountW'(1) : low_cnt_q;

	assign search_start = (state_q == StEval) && (kind_q == ReqTemp) && !is_short && !is_open;

	assign idx_ext    = ExtW'(search_idx);
	assign temp_found = (idx_ext > ExtW'(MaxTemp)) ? MaxTemp : TempW'(search_idx);

	ntc_tlc_search #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.start (search_start),
		.value (filt_new),
		.done  (search_done),
		.index (search_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			StIdle: begin
				if (req_acc) begin
					state_d = StEval;
				end
			end
			StEval: begin
				state_d = search_start ? StSearch : StDone;
			end
			StSearch: begin
				if (search_done) begin
					state_d = StDone;
				end
			end
			StDone: begin
				if (out_free) begin
					state_d = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_thr_q <= ShortThrReset;
			open_thr_q  <= OpenThrReset;
			water_thr_q <= WaterThrReset;
			water_cnt_q <= WaterCntReset;
			water_min_q <= WaterMinReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegShortThr: short_thr_q <= cfg_data;
				RegOpenThr:  open_thr_q  <= cfg_data;
				RegWaterThr: water_thr_q <= cfg_data;
				RegWaterCnt: water_cnt_q <= cfg_data[CountW-1:0];
				RegWaterMin: water_min_q <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q <= req.req_type;
			x_q    <= req.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q    <= FilterReset;
			temp_q    <= '0;
			present_q <= 1'b0;
			short_q   <= 1'b0;
			open_q    <= 1'b0;
			active_q  <= 1'b0;
			low_q     <= 1'b0;
			reload_q  <= 1'b0;
			lvl_cnt_q <= '0;
			low_cnt_q <= '0;
		end else begin
			if (req_acc) begin
				reload_q <= 1'b0;
			end
			if (state_q == StEval) begin
				if (kind_q == ReqTemp) begin
					if (is_short) begin
						short_q   <= 1'b1;
						open_q    <= 1'b0;
						present_q <= 1'b0;
						reload_q  <= 1'b1;
					end else if (is_open) begin
						short_q   <= 1'b0;
						open_q    <= 1'b1;
						present_q <= 1'b0;
						temp_q    <= OpenTemp;
						reload_q  <= 1'b1;
					end else begin
						short_q   <= 1'b0;
						open_q    <= 1'b0;
						present_q <= 1'b1;
						filt_q    <= filt_new;
						if (!present_q) begin
							active_q  <= 1'b1;
							lvl_cnt_q <= '0;
							low_cnt_q <= '0;
							reload_q  <= 1'b1;
						end
					end
				end else if (active_q) begin
					if (lvl_cnt_inc >= water_cnt_q) begin
						low_q     <= (low_cnt_inc >= water_min_q);
						active_q  <= 1'b0;
						lvl_cnt_q <= '0;
						low_cnt_q <= '0;
					end else begin
						lvl_cnt_q <= lvl_cnt_inc;
						low_cnt_q <= low_cnt_inc;
					end
				end
			end
			if ((state_q == StSearch) && search_done) begin
				temp_q <= temp_found;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == StDone) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == StDone) && out_free) begin
			rsp_q.temperature       <= temp_q;
			rsp_q.short_fault       <= short_q;
			rsp_q.open_fault        <= open_q;
			rsp_q.kettle_present    <= present_q;
			rsp_q.level_test_active <= active_q;
			rsp_q.water_low         <= low_q;
			rsp_q.pad_timer_reload  <= reload_q;
		end
	end

endmodule

// ----- hw/rtl/ntc_tlc_checker.sv -----
`include "ntc_temperature_and_level_check_core_assert.svh"

module ntc_tlc_checker
	import ntc_tlc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic faults_ok, present_ok;

	assign faults_ok  = !(rsp.short_fault && rsp.open_fault);
	assign present_ok = !rsp.short_fault && !rsp.open_fault && (rsp.temperature <= MaxTemp);

	// one request at a time
	`NTC_TLC_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && !req_stall, req_stall)

	`NTC_TLC_ASSERT_NOW(a_faults_exclusive, clk, arst_n, rsp_valid, faults_ok)

	`NTC_TLC_ASSERT_NOW(a_present_no_fault, clk, arst_n, rsp_valid && rsp.kettle_present, present_ok)

	`NTC_TLC_ASSERT_NOW(a_open_temp, clk, arst_n, rsp_valid && rsp.open_fault, rsp.temperature == OpenTemp)

	`NTC_TLC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind ntc_temperature_and_level_check_core ntc_tlc_checker u_ntc_tlc_checker (.*);
